// File: rtl/dmtg_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the disk mesh triangle generator.
package dmtg_pkg;

   localparam int VertexWidth    = 14;
   localparam int RingCountWidth = 7;

   localparam logic [RingCountWidth-1:0] RING_COUNT_RESET = 7'd1;

   typedef logic [VertexWidth-1:0]    vertex_type;
   typedef logic [RingCountWidth-1:0] ring_count_type;

   // Step within the current ring.
   typedef enum logic [1:0] {
      PHASE_SINGLE_OR_FIRST = 2'd0,
      PHASE_SECOND          = 2'd1,
      PHASE_CLOSE_FIRST     = 2'd2,
      PHASE_CLOSE_SECOND    = 2'd3
   } phase_type;

   typedef struct packed {
      vertex_type vertex_a;
      vertex_type vertex_b;
      vertex_type vertex_c;
      logic       valid_res;
      logic       last;
   } triangle_type;

endpackage

// File: rtl/dmtg_req_if.sv
`timescale 1ns / 1ps
// Request channel interface carrying the restart flag.
interface dmtg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

// File: rtl/dmtg_rsp_if.sv
`timescale 1ns / 1ps
// Response channel interface carrying one triangle.
interface dmtg_rsp_if;
   logic                valid;
   logic                ready;
   dmtg_pkg::vertex_type vertex_a;
   dmtg_pkg::vertex_type vertex_b;
   dmtg_pkg::vertex_type vertex_c;
   logic                valid_res;
   logic                last;

   modport source (output valid, output vertex_a, output vertex_b, output vertex_c,
                   output valid_res, output last, input ready);
   modport sink (input valid, input vertex_a, input vertex_b, input vertex_c,
                 input valid_res, input last, output ready);
endinterface

// File: rtl/dmtg_sequencer.sv
`timescale 1ns / 1ps
// Ring counters, ring count register and the triangle selection logic.
module dmtg_sequencer #(
   parameter int MAX_RINGS = 64
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  dmtg_pkg::ring_count_type csr_wr_data,
   input  logic                    accept,
   input  logic                    restart,
   output dmtg_pkg::triangle_type  result
);

   localparam int IW = $clog2(MAX_RINGS + 1);
   localparam int PW = $clog2(6 * MAX_RINGS + 1);
   localparam int BW = $clog2(3 * MAX_RINGS * (MAX_RINGS + 1) + 2);

   dmtg_pkg::ring_count_type ring_count_ff;
   logic [IW-1:0]            ring_index_ff, ring_index_in;
   logic [PW-1:0]            ring_position_ff, ring_position_in;
   logic [PW-1:0]            inner_advance_ff, inner_advance_in;
   logic [IW-1:0]            position_mod_ring_ff, position_mod_ring_in;
   dmtg_pkg::phase_type      pair_phase_ff, pair_phase_in;
   logic [BW-1:0]            inner_ring_base_ff, inner_ring_base_in;
   logic [BW-1:0]            outer_ring_base_ff, outer_ring_base_in;
   logic [PW-1:0]            ring_span_ff, ring_span_in;
   logic                     sequence_done_ff, sequence_done_in;

   logic [IW-1:0]       rings_used;
   logic [IW-1:0]       cur_index;
   logic [PW-1:0]       cur_pos;
   logic [PW-1:0]       cur_adv;
   logic [IW-1:0]       cur_mod;
   dmtg_pkg::phase_type cur_phase;
   logic [BW-1:0]       cur_inner;
   logic [BW-1:0]       cur_outer;
   logic [PW-1:0]       cur_span;
   logic                cur_done;

   logic [BW-1:0] o_j, o_j1, ib_k, ib_k1, o_end;
   logic [PW-1:0] pos_inc;
   logic [IW-1:0] mod_inc;
   logic          last_pos;
   logic          do_close;
   logic          do_advance;

   always_comb begin
      if (ring_count_ff == '0) begin
         rings_used = IW'(1);
      end else if (32'(ring_count_ff) > 32'(MAX_RINGS)) begin
         rings_used = IW'(MAX_RINGS);
      end else begin
         rings_used = IW'(ring_count_ff);
      end
   end

   // A restart request sees the start-of-sequence state.
   always_comb begin
      if (restart) begin
         cur_index = IW'(1);
         cur_pos   = '0;
         cur_adv   = '0;
         cur_mod   = '0;
         cur_phase = dmtg_pkg::PHASE_SINGLE_OR_FIRST;
         cur_inner = BW'(1);
         cur_outer = BW'(1);
         cur_span  = PW'(6);
         cur_done  = 1'b0;
      end else begin
         cur_index = ring_index_ff;
         cur_pos   = ring_position_ff;
         cur_adv   = inner_advance_ff;
         cur_mod   = position_mod_ring_ff;
         cur_phase = pair_phase_ff;
         cur_inner = inner_ring_base_ff;
         cur_outer = outer_ring_base_ff;
         cur_span  = ring_span_ff;
         cur_done  = sequence_done_ff;
      end
   end

   assign o_j      = cur_outer + BW'(cur_pos);
   assign o_j1     = o_j + BW'(1);
   assign ib_k     = cur_inner + BW'(cur_adv);
   assign ib_k1    = ib_k + BW'(1);
   assign o_end    = cur_outer + BW'(cur_span) - BW'(1);
   assign pos_inc  = cur_pos + PW'(1);
   assign mod_inc  = cur_mod + IW'(1);
   assign last_pos = (pos_inc >= cur_span - PW'(1));

   always_comb begin
      ring_index_in        = cur_index;
      ring_position_in     = cur_pos;
      inner_advance_in     = cur_adv;
      position_mod_ring_in = cur_mod;
      pair_phase_in        = cur_phase;
      inner_ring_base_in   = cur_inner;
      outer_ring_base_in   = cur_outer;
      ring_span_in         = cur_span;
      sequence_done_in     = cur_done;
      result               = '0;
      do_close             = 1'b0;
      do_advance           = 1'b0;

      if (!cur_done) begin
         result.valid_res = 1'b1;
         if (cur_index == IW'(1)) begin
            result.vertex_a = dmtg_pkg::vertex_type'(o_j);
            result.vertex_b = (cur_pos >= PW'(5)) ? dmtg_pkg::vertex_type'(cur_outer)
                                                  : dmtg_pkg::vertex_type'(o_j1);
            ring_position_in = pos_inc;
            do_close         = (pos_inc >= PW'(6));
         end else begin
            case (cur_phase)
               dmtg_pkg::PHASE_SINGLE_OR_FIRST: begin
                  if (cur_mod != '0) begin
                     result.vertex_a = dmtg_pkg::vertex_type'(ib_k1);
                     result.vertex_b = dmtg_pkg::vertex_type'(ib_k);
                     result.vertex_c = dmtg_pkg::vertex_type'(o_j);
                     pair_phase_in   = dmtg_pkg::PHASE_SECOND;
                  end else begin
                     result.vertex_a = dmtg_pkg::vertex_type'(o_j);
                     result.vertex_b = dmtg_pkg::vertex_type'(o_j1);
                     result.vertex_c = dmtg_pkg::vertex_type'(ib_k);
                     do_advance      = 1'b1;
                  end
               end
               dmtg_pkg::PHASE_SECOND: begin
                  result.vertex_a  = dmtg_pkg::vertex_type'(ib_k1);
                  result.vertex_b  = dmtg_pkg::vertex_type'(o_j);
                  result.vertex_c  = dmtg_pkg::vertex_type'(o_j1);
                  inner_advance_in = cur_adv + PW'(1);
                  do_advance       = 1'b1;
               end
               dmtg_pkg::PHASE_CLOSE_FIRST: begin
                  result.vertex_a = dmtg_pkg::vertex_type'(cur_outer);
                  result.vertex_b = dmtg_pkg::vertex_type'(o_end);
                  result.vertex_c = dmtg_pkg::vertex_type'(cur_inner);
                  pair_phase_in   = dmtg_pkg::PHASE_CLOSE_SECOND;
               end
               default: begin
                  result.vertex_a = dmtg_pkg::vertex_type'(cur_inner);
                  result.vertex_b = dmtg_pkg::vertex_type'(ib_k);
                  result.vertex_c = dmtg_pkg::vertex_type'(o_end);
                  do_close        = 1'b1;
               end
            endcase
         end

         if (do_advance) begin
            ring_position_in     = pos_inc;
            position_mod_ring_in = (mod_inc >= cur_index) ? '0 : mod_inc;
            pair_phase_in        = last_pos ? dmtg_pkg::PHASE_CLOSE_FIRST
                                            : dmtg_pkg::PHASE_SINGLE_OR_FIRST;
         end

         if (do_close) begin
            if (cur_index >= rings_used) begin
               sequence_done_in = 1'b1;
               result.last      = 1'b1;
            end else begin
               inner_ring_base_in   = cur_outer;
               outer_ring_base_in   = cur_outer + BW'(cur_span);
               ring_span_in         = cur_span + PW'(6);
               ring_index_in        = cur_index + IW'(1);
               ring_position_in     = '0;
               inner_advance_in     = '0;
               position_mod_ring_in = '0;
               pair_phase_in        = dmtg_pkg::PHASE_SINGLE_OR_FIRST;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         ring_count_ff        <= reset ? dmtg_pkg::RING_COUNT_RESET : csr_wr_data;
         ring_index_ff        <= IW'(1);
         ring_position_ff     <= '0;
         inner_advance_ff     <= '0;
         position_mod_ring_ff <= '0;
         pair_phase_ff        <= dmtg_pkg::PHASE_SINGLE_OR_FIRST;
         inner_ring_base_ff   <= BW'(1);
         outer_ring_base_ff   <= BW'(1);
         ring_span_ff         <= PW'(6);
         sequence_done_ff     <= 1'b0;
      end else if (accept) begin
         ring_index_ff        <= ring_index_in;
         ring_position_ff     <= ring_position_in;
         inner_advance_ff     <= inner_advance_in;
         position_mod_ring_ff <= position_mod_ring_in;
         pair_phase_ff        <= pair_phase_in;
         inner_ring_base_ff   <= inner_ring_base_in;
         outer_ring_base_ff   <= outer_ring_base_in;
         ring_span_ff         <= ring_span_in;
         sequence_done_ff     <= sequence_done_in;
      end
   end

endmodule

// File: rtl/dmtg_out_reg.sv
`timescale 1ns / 1ps
// Response register that holds one triangle until the consumer takes it.
module dmtg_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  dmtg_pkg::triangle_type result,
   output logic                   load_ready,
   dmtg_rsp_if.source             rsp_bus
);

   logic                   rsp_valid_ff, rsp_valid_in;
   dmtg_pkg::triangle_type payload_ff;

   assign load_ready   = !rsp_valid_ff || rsp_bus.ready;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         payload_ff <= result;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.vertex_a  = payload_ff.vertex_a;
   assign rsp_bus.vertex_b  = payload_ff.vertex_b;
   assign rsp_bus.vertex_c  = payload_ff.vertex_c;
   assign rsp_bus.valid_res = payload_ff.valid_res;
   assign rsp_bus.last      = payload_ff.last;

endmodule

// File: rtl/disk_mesh_triangle_generator_core.sv
`timescale 1ns / 1ps
// Top level of the disk mesh triangle generator.
// A triangle appears on the response channel in the cycle after its request is accepted.
// One request per cycle while the response register can take it; the ring counters advance once per triangle.
// A request is accepted whenever the response register is empty or being emptied.
// Reset is synchronous and active high; it sets the ring count to one and rewinds the sequence.
module disk_mesh_triangle_generator_core #(
   parameter int MAX_RINGS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  dmtg_pkg::ring_count_type csr_wr_data,
   dmtg_req_if.sink                 req_bus,
   dmtg_rsp_if.source               rsp_bus
);

   dmtg_pkg::triangle_type result;
   logic                   load_ready;
   logic                   accept;

   assign req_bus.ready = load_ready;
   assign accept        = req_bus.valid && load_ready;

   dmtg_sequencer #(
      .MAX_RINGS (MAX_RINGS)
   ) u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .restart     (req_bus.restart),
      .result      (result)
   );

   dmtg_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .result     (result),
      .load_ready (load_ready),
      .rsp_bus    (rsp_bus)
   );

endmodule

// File: rtl/dmtg_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the triangle generator and their binding.
module dmtg_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input dmtg_pkg::vertex_type rsp_vertex_a,
   input dmtg_pkg::vertex_type rsp_vertex_b,
   input dmtg_pkg::vertex_type rsp_vertex_c,
   input logic                 rsp_valid_res,
   input logic                 rsp_last
);

   // A stalled response keeps its triangle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_vertex_a)
         && $stable(rsp_vertex_b) && $stable(rsp_vertex_c) && $stable(rsp_last))
      else $error("stalled response changed");

   // Every accepted request yields a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted request produced no response");

   // An exhausted response carries no triangle and no end marker.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> !rsp_last && rsp_vertex_a == '0
         && rsp_vertex_b == '0 && rsp_vertex_c == '0)
      else $error("exhausted response is not cleared");

   // The response register is empty right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind disk_mesh_triangle_generator_core dmtg_checker u_dmtg_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_vertex_a  (rsp_bus.vertex_a),
   .rsp_vertex_b  (rsp_bus.vertex_b),
   .rsp_vertex_c  (rsp_bus.vertex_c),
   .rsp_valid_res (rsp_bus.valid_res),
   .rsp_last      (rsp_bus.last)
);

// File: verif/dmtg_triangle_checker.sv
`timescale 1ns / 1ps
// Checker that predicts each disk mesh triangle and compares it with the response channel.
module dmtg_triangle_checker #(
   parameter int MAX_RINGS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  dmtg_pkg::ring_count_type csr_wr_data,
   dmtg_req_if                      req_mon,
   dmtg_rsp_if                      rsp_mon,
   output int                       mismatch_count,
   output int                       triangles_owed
);

   int                     rings_used = 1;
   int                     ring_index;
   int                     ring_pos;
   int                     inner_step;
   int                     pos_in_ring;
   dmtg_pkg::phase_type    phase;
   int                     inner_base;
   int                     outer_base;
   bit                     mesh_done;
   int                     errors = 0;
   dmtg_pkg::triangle_type owed_q[$];

   function automatic void rewind_mesh();
      ring_index  = 1;
      ring_pos    = 0;
      inner_step  = 0;
      pos_in_ring = 0;
      phase       = dmtg_pkg::PHASE_SINGLE_OR_FIRST;
      inner_base  = 1;
      outer_base  = 1;
      mesh_done   = 1'b0;
   endfunction

   function automatic bit finish_ring();
      if (ring_index >= rings_used) begin
         mesh_done = 1'b1;
         return 1'b1;
      end
      inner_base  = outer_base;
      outer_base += 6 * ring_index;
      ring_index++;
      ring_pos    = 0;
      inner_step  = 0;
      pos_in_ring = 0;
      phase       = dmtg_pkg::PHASE_SINGLE_OR_FIRST;
      return 1'b0;
   endfunction

   function automatic void advance_position();
      ring_pos++;
      pos_in_ring++;
      if (pos_in_ring >= ring_index) pos_in_ring = 0;
      phase = (ring_pos >= 6 * ring_index - 1) ? dmtg_pkg::PHASE_CLOSE_FIRST
                                               : dmtg_pkg::PHASE_SINGLE_OR_FIRST;
   endfunction

   function automatic dmtg_pkg::triangle_type next_triangle(input logic restart);
      int                     a;
      int                     b;
      int                     c;
      bit                     fin;
      dmtg_pkg::triangle_type tri_out;
      a   = 0;
      b   = 0;
      c   = 0;
      fin = 1'b0;
      if (restart) rewind_mesh();
      if (mesh_done) return '0;
      if (ring_index == 1) begin
         a = outer_base + ring_pos;
         b = (ring_pos >= 5) ? outer_base : outer_base + ring_pos + 1;
         ring_pos++;
         if (ring_pos >= 6) fin = finish_ring();
      end else begin
         case (phase)
            dmtg_pkg::PHASE_SINGLE_OR_FIRST: begin
               if (pos_in_ring != 0) begin
                  a = inner_base + inner_step + 1;
                  b = inner_base + inner_step;
                  c = outer_base + ring_pos;
                  phase = dmtg_pkg::PHASE_SECOND;
               end else begin
                  a = outer_base + ring_pos;
                  b = outer_base + ring_pos + 1;
                  c = inner_base + inner_step;
                  advance_position();
               end
            end
            dmtg_pkg::PHASE_SECOND: begin
               a = inner_base + inner_step + 1;
               b = outer_base + ring_pos;
               c = outer_base + ring_pos + 1;
               inner_step++;
               advance_position();
            end
            dmtg_pkg::PHASE_CLOSE_FIRST: begin
               a = outer_base;
               b = outer_base + 6 * ring_index - 1;
               c = inner_base;
               phase = dmtg_pkg::PHASE_CLOSE_SECOND;
            end
            default: begin
               a = inner_base;
               b = inner_base + inner_step;
               c = outer_base + 6 * ring_index - 1;
               fin = finish_ring();
            end
         endcase
      end
      tri_out.vertex_a  = a[dmtg_pkg::VertexWidth-1:0];
      tri_out.vertex_b  = b[dmtg_pkg::VertexWidth-1:0];
      tri_out.vertex_c  = c[dmtg_pkg::VertexWidth-1:0];
      tri_out.valid_res = 1'b1;
      tri_out.last      = fin;
      return tri_out;
   endfunction

   always @(posedge clock) begin
      dmtg_pkg::triangle_type seen;
      dmtg_pkg::triangle_type want;
      if (reset) begin
         rings_used = int'(dmtg_pkg::RING_COUNT_RESET);
         rewind_mesh();
         owed_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = {rsp_mon.vertex_a, rsp_mon.vertex_b, rsp_mon.vertex_c,
                    rsp_mon.valid_res, rsp_mon.last};
            if (owed_q.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected triangle (%0d,%0d,%0d) valid_res=%0b last=%0b",
                           $realtime, seen.vertex_a, seen.vertex_b, seen.vertex_c,
                           seen.valid_res, seen.last);
            end else begin
               want = owed_q.pop_front();
               if (seen !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%0t: expected (%0d,%0d,%0d) v=%0b l=%0b, ",
                               "got (%0d,%0d,%0d) v=%0b l=%0b"},
                              $realtime, want.vertex_a, want.vertex_b, want.vertex_c,
                              want.valid_res, want.last, seen.vertex_a, seen.vertex_b,
                              seen.vertex_c, seen.valid_res, seen.last);
               end
            end
         end
         if (csr_wr_en) begin
            rings_used = (csr_wr_data == 0) ? 1 :
                         (int'(csr_wr_data) > MAX_RINGS) ? MAX_RINGS : int'(csr_wr_data);
            rewind_mesh();
         end
         if (req_mon.valid && req_mon.ready) owed_q.push_back(next_triangle(req_mon.restart));
      end
      mismatch_count <= errors;
      triangles_owed <= owed_q.size();
   end

endmodule

// File: verif/disk_mesh_triangle_generator_core_tb.sv
`timescale 1ns / 1ps
// Testbench top that drives requests and ring count writes and reports the verdict.
module disk_mesh_triangle_generator_core_tb;

   localparam int MaxRings       = 64;
   localparam int RandomRequests = 550;
   localparam int CycleLimit     = 200000;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   dmtg_pkg::ring_count_type csr_wr_data;
   int                       mismatch_count;
   int                       triangles_owed;
   int                       cycles = 0;
   bit                       steady_flow = 1'b0;

   dmtg_req_if req_bus();
   dmtg_rsp_if rsp_bus();

   disk_mesh_triangle_generator_core #(
      .MAX_RINGS(MaxRings)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus)
   );

   dmtg_triangle_checker #(
      .MAX_RINGS(MaxRings)
   ) mesh_check (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_mon       (req_bus),
      .rsp_mon       (rsp_bus),
      .mismatch_count(mismatch_count),
      .triangles_owed(triangles_owed)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= steady_flow || ($urandom_range(0, 99) >= 6);
      end
   end

   initial begin
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send_request(input logic restart);
      if (!steady_flow && $urandom_range(0, 99) < 6) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (triangles_owed != 0);
   endtask

   task automatic set_ring_count(input dmtg_pkg::ring_count_type value);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int pick;
      int rings;
      int span;
      int random_sent;
      bit noisy;
      reset           <= 1'b1;
      csr_wr_en       <= 1'b0;
      csr_wr_data     <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.restart <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Ring count of one after reset: the center fan, an exhausted request, then a restart.
      repeat (7) send_request(1'b0);
      send_request(1'b1);
      send_request(1'b0);
      set_ring_count(7'd0);
      repeat (7) send_request(1'b0);
      set_ring_count(7'd127);
      repeat (9) send_request(1'b0);

      random_sent = 0;
      while (random_sent < RandomRequests) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) rings = $urandom_range(1, 4);
         else if (pick < 80) rings = $urandom_range(5, 10);
         else if (pick < 85) rings = 0;
         else if (pick < 90) rings = MaxRings;
         else rings = $urandom_range(MaxRings + 1, 127);
         set_ring_count(dmtg_pkg::ring_count_type'(rings));
         span = (rings == 0) ? 1 : (rings > MaxRings) ? MaxRings : rings;
         span = 6 * span * span;
         span = (span > 120) ? $urandom_range(30, 120) : span + $urandom_range(0, 3);
         noisy = $urandom_range(0, 99) < 20;
         for (int k = 0; k < span; k++) begin
            steady_flow <= (random_sent >= 150) && (random_sent < 300);
            send_request(noisy ? ($urandom_range(0, 99) < 25) : ($urandom_range(0, 199) == 0));
            random_sent++;
            if ($urandom_range(0, 199) == 0) drain_responses();
         end
      end

      drain_responses();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0 && triangles_owed == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
